### rtl/bicubic_patch_interpolator_macros.svh
// ----------------------------------------------------------------------------
// Bicubic patch interpolator assertion macros
// Shared concurrent assertion forms for the interpolator RTL.
// ----------------------------------------------------------------------------
`ifndef BICUBIC_PATCH_INTERPOLATOR_MACROS_SVH
`define BICUBIC_PATCH_INTERPOLATOR_MACROS_SVH

// same-cycle implication, disabled while in reset
`define BPI_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("bicubic_patch_interpolator: implication failed");

// next-cycle implication, disabled while in reset
`define BPI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bicubic_patch_interpolator: next-cycle check failed");

`endif

### rtl/bpi_pkg.sv
// ----------------------------------------------------------------------------
// Bicubic patch interpolator package
// Shared constants and types for the interpolator pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package bpi_pkg;

   localparam int PIXEL_BITS    = 8;
   localparam int FRAC_BITS_DEF = 8;
   localparam int FRAC_IN_W     = 8;
   localparam int NUM_TAPS      = 4;
   localparam int ROW_W         = NUM_TAPS * PIXEL_BITS;
   localparam int TAP_W         = PIXEL_BITS + 1;
   localparam int CUBIC_LAT     = 4;

   localparam logic [PIXEL_BITS-1:0] PIX_MAX = {PIXEL_BITS{1'b1}};

   typedef logic [PIXEL_BITS-1:0] pixel_type;
   typedef logic [ROW_W-1:0]      row_type;

endpackage

`default_nettype wire

### rtl/bpi_cubic.sv
// ----------------------------------------------------------------------------
// Bicubic patch interpolator cubic stage
// Four-stage pipeline: coefficient fit, then three Horner steps at f/2^F.
// ----------------------------------------------------------------------------
`default_nettype none

module bpi_cubic #(
   parameter int IN_W      = bpi_pkg::TAP_W,
   parameter int FRAC_BITS = bpi_pkg::FRAC_BITS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              in_valid,
   input  wire  signed [IN_W-1:0]           q0,
   input  wire  signed [IN_W-1:0]           q1,
   input  wire  signed [IN_W-1:0]           q2,
   input  wire  signed [IN_W-1:0]           q3,
   input  wire         [FRAC_BITS-1:0]      f,
   output logic                             out_valid,
   output logic signed [IN_W+4+3*FRAC_BITS-1:0] result
);

   localparam int AW = IN_W + 2;
   localparam int BW = IN_W + 3;
   localparam int CW = IN_W + 1;
   localparam int H1 = IN_W + 4 + FRAC_BITS;
   localparam int H2 = IN_W + 4 + 2 * FRAC_BITS;
   localparam int H3 = IN_W + 4 + 3 * FRAC_BITS;

   logic signed [AW-1:0]   a_in, a_ff;
   logic signed [BW-1:0]   b_in, b_ff;
   logic signed [CW-1:0]   c_in, c_ff, c1_ff;
   logic signed [IN_W-1:0] d_ff, d1_ff, d2_ff;
   logic [FRAC_BITS-1:0]   f0_ff, f1_ff, f2_ff;
   logic signed [H1-1:0]   acc1_in, acc1_ff;
   logic signed [H2-1:0]   acc2_in, acc2_ff;
   logic signed [H3-1:0]   acc3_in, acc3_ff;
   logic                   v0_ff, v1_ff, v2_ff, v3_ff;

   always_comb begin
      a_in = AW'(q3) - AW'(q2) - AW'(q0) + AW'(q1);
      b_in = BW'(q0) - BW'(q1) - BW'(a_in);
      c_in = CW'(q2) - CW'(q0);
      acc1_in = H1'(a_ff) * H1'($signed({1'b0, f0_ff})) + (H1'(b_ff) <<< FRAC_BITS);
      acc2_in = H2'(acc1_ff) * H2'($signed({1'b0, f1_ff}))
              + (H2'(c1_ff) <<< (2 * FRAC_BITS));
      acc3_in = H3'(acc2_ff) * H3'($signed({1'b0, f2_ff}))
              + (H3'(d2_ff) <<< (3 * FRAC_BITS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      c_ff    <= c_in;
      d_ff    <= q1;
      f0_ff   <= f;
      acc1_ff <= acc1_in;
      c1_ff   <= c_ff;
      d1_ff   <= d_ff;
      f1_ff   <= f0_ff;
      acc2_ff <= acc2_in;
      d2_ff   <= d1_ff;
      f2_ff   <= f1_ff;
      acc3_ff <= acc3_in;
   end

   assign out_valid = v3_ff;
   assign result    = acc3_ff;

endmodule

`default_nettype wire

### rtl/bicubic_patch_interpolator.sv
// ----------------------------------------------------------------------------
// Bicubic patch interpolator
// Throughput: one request per cycle while busy is low; ten register stages: input, two cubic
// passes of four (fit, then three Horner multiplies) and the saturating output.
// The result channel has no backpressure; busy is high only during reset.
// Reset clears every stage valid bit; pipeline payload is not reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bicubic_patch_interpolator_macros.svh"

module bicubic_patch_interpolator #(
   parameter int FRAC_BITS = bpi_pkg::FRAC_BITS_DEF
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            start,
   output logic                           busy,
   input  wire  bpi_pkg::row_type         req_row0,
   input  wire  bpi_pkg::row_type         req_row1,
   input  wire  bpi_pkg::row_type         req_row2,
   input  wire  bpi_pkg::row_type         req_row3,
   input  wire  [bpi_pkg::FRAC_IN_W-1:0]  req_frac_row,
   input  wire  [bpi_pkg::FRAC_IN_W-1:0]  req_frac_col,
   output logic                           rsp_strobe,
   output bpi_pkg::pixel_type             rsp_pixel,
   output logic                           rsp_clipped
);

   import bpi_pkg::*;

   localparam int FI       = (FRAC_BITS < FRAC_IN_W) ? FRAC_BITS : FRAC_IN_W;
   localparam int RW       = TAP_W + 4 + 3 * FRAC_BITS;
   localparam int VW       = RW + 4 + 3 * FRAC_BITS;
   localparam int SHIFT    = 6 * FRAC_BITS;
   localparam int PIPE_LAT = 2 * CUBIC_LAT + 2;

   logic                 busy_ff;
   logic                 accept;
   logic                 in_v_ff;
   row_type              row_ff [NUM_TAPS];
   logic [FRAC_BITS-1:0] fr_ff, fc_ff;
   logic [FRAC_BITS-1:0] fr_d_ff [CUBIC_LAT];

   logic signed [TAP_W-1:0] tap [NUM_TAPS][NUM_TAPS];
   logic signed [RW-1:0]    row_val [NUM_TAPS];
   logic [NUM_TAPS-1:0]     row_valid;

   logic                 col_valid;
   logic signed [VW-1:0] col_val;

   logic      out_v_ff;
   pixel_type pixel_in, pixel_ff;
   logic      clip_in, clip_ff;

   assign accept = start && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         in_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         busy_ff  <= 1'b0;
         in_v_ff  <= accept;
         out_v_ff <= col_valid;
      end
   end

   always_ff @(posedge clock) begin
      row_ff[0] <= req_row0;
      row_ff[1] <= req_row1;
      row_ff[2] <= req_row2;
      row_ff[3] <= req_row3;
      fr_ff     <= FRAC_BITS'(req_frac_row[FI-1:0]);
      fc_ff     <= FRAC_BITS'(req_frac_col[FI-1:0]);
      fr_d_ff[0] <= fr_ff;
      for (int i = 1; i < CUBIC_LAT; i++) begin
         fr_d_ff[i] <= fr_d_ff[i-1];
      end
      pixel_ff <= pixel_in;
      clip_ff  <= clip_in;
   end

   always_comb begin
      for (int r = 0; r < NUM_TAPS; r++) begin
         for (int k = 0; k < NUM_TAPS; k++) begin
            tap[r][k] = $signed({1'b0, row_ff[r][k*PIXEL_BITS +: PIXEL_BITS]});
         end
      end
   end

   for (genvar r = 0; r < NUM_TAPS; r++) begin : g_row
      bpi_cubic #(
         .IN_W      (TAP_W),
         .FRAC_BITS (FRAC_BITS)
      ) u_row (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (in_v_ff),
         .q0        (tap[r][0]),
         .q1        (tap[r][1]),
         .q2        (tap[r][2]),
         .q3        (tap[r][3]),
         .f         (fc_ff),
         .out_valid (row_valid[r]),
         .result    (row_val[r])
      );
   end

   bpi_cubic #(
      .IN_W      (RW),
      .FRAC_BITS (FRAC_BITS)
   ) u_col (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (row_valid[0]),
      .q0        (row_val[0]),
      .q1        (row_val[1]),
      .q2        (row_val[2]),
      .q3        (row_val[3]),
      .f         (fr_d_ff[CUBIC_LAT-1]),
      .out_valid (col_valid),
      .result    (col_val)
   );

   always_comb begin
      if (col_val[VW-1]) begin
         pixel_in = '0;
         clip_in  = 1'b1;
      end else if (|col_val[VW-1:SHIFT+PIXEL_BITS]) begin
         pixel_in = PIX_MAX;
         clip_in  = 1'b1;
      end else begin
         pixel_in = col_val[SHIFT +: PIXEL_BITS];
         clip_in  = 1'b0;
      end
   end

   assign busy        = busy_ff;
   assign rsp_strobe  = out_v_ff;
   assign rsp_pixel   = pixel_ff;
   assign rsp_clipped = clip_ff;

   `BPI_ASSERT_IMPL(a_latency, clock, reset, accept, ##PIPE_LAT rsp_strobe)
   `BPI_ASSERT_IMPL(a_rows_aligned, clock, reset, |row_valid, (&row_valid))
   `BPI_ASSERT_IMPL(a_clip_code, clock, reset, rsp_strobe && rsp_clipped,
      (rsp_pixel == '0 || rsp_pixel == PIX_MAX))
   `BPI_ASSERT_NEXT(a_col_follows, clock, reset, col_valid, rsp_strobe)

endmodule

`default_nettype wire
